### design/hrm_pkg.sv
// ----------------------------------------------------------------------------
// HSV range mask package
// Shared widths, register codes and the divider step used by the pipeline.
// ----------------------------------------------------------------------------
package hrm_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned NUM_DIV_STEPS = 8;
  localparam int unsigned STEP_W        = $clog2(NUM_DIV_STEPS);
  localparam int unsigned QUO_W         = NUM_DIV_STEPS;
  localparam int unsigned NUM_W         = 17;
  localparam int unsigned DVS_W         = 9;
  localparam int unsigned UN_W          = 11;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned DATA_W        = 32;

  localparam logic [PIX_W-1:0] HUE_WRAP = 8'd180;

  localparam logic [PIX_W-1:0] HUE_LOW_RST  = 8'd0;
  localparam logic [PIX_W-1:0] HUE_HIGH_RST = 8'd179;
  localparam logic [PIX_W-1:0] SAT_LOW_RST  = 8'd0;
  localparam logic [PIX_W-1:0] SAT_HIGH_RST = 8'd255;
  localparam logic [PIX_W-1:0] VAL_LOW_RST  = 8'd0;
  localparam logic [PIX_W-1:0] VAL_HIGH_RST = 8'd255;

  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_VAL_LOW  = 3'd4,
    REG_VAL_HIGH = 3'd5
  } reg_idx_e;

  // One division in flight: partial remainder, divisor and quotient so far.
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // Everything a pixel carries through the divider stages.
  typedef struct packed {
    div_lane_t        sat;
    div_lane_t        hue;
    logic [PIX_W-1:0] val;
  } div_item_t;

  // One restoring step: settles quotient bit k.
  function automatic div_lane_t div_step(div_lane_t lane, logic [STEP_W-1:0] k);
    logic [NUM_W-1:0] trial;
    div_lane_t        res;
    trial = NUM_W'(lane.dvs) << k;
    res   = lane;
    if (lane.rem >= trial) begin
      res.rem    = lane.rem - trial;
      res.quo[k] = 1'b1;
    end
    return res;
  endfunction

endpackage

### design/hrm_div_stage.sv
// ----------------------------------------------------------------------------
// HSV range mask divider stage
// Settles one quotient bit of both divisions and registers the pixel.
// ----------------------------------------------------------------------------
module hrm_div_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [hrm_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  hrm_pkg::div_item_t            data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output hrm_pkg::div_item_t            data_o
);

  logic               valid_q;
  hrm_pkg::div_item_t data_q;
  hrm_pkg::div_item_t data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d     = data_i;
    data_d.sat = hrm_pkg::div_step(data_i.sat, step_i);
    data_d.hue = hrm_pkg::div_step(data_i.hue, step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### design/hsv_range_mask.sv
// ----------------------------------------------------------------------------
// HSV range mask
// Converts a BGR pixel to 8-bit HSV and flags whether it lies inside a box.
// ----------------------------------------------------------------------------
// The block takes one BGR pixel per clock while the output side does not
// stall and returns its hue (half-degrees, 0 to 179), saturation and value
// together with a mask bit that is set when all three lie within the
// inclusive bounds held in six APB registers. The pipeline accepts a request
// in every cycle when the output side does not stall. In order, one stage
// finds the largest and smallest component and the hue offset, one forms the
// two dividends, eight stages each settle one quotient bit of the saturation
// and hue divisions side by side, and a last stage wraps the hue, checks the
// bounds and holds the result. Every stage has its own valid bit and only
// waits when the stage after it is full and stalled, so bubbles are squeezed
// out while the output is held. The bounds are read in the last stage and
// should only be written while no request is in the pipeline; pready is
// always high and reads return the stored value in the low byte.
module hsv_range_mask (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel requests.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hrm_pkg::PIX_W-1:0]     blue_i,
  input  logic [hrm_pkg::PIX_W-1:0]     green_i,
  input  logic [hrm_pkg::PIX_W-1:0]     red_i,
  // Results.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          in_range_o,
  output logic [hrm_pkg::PIX_W-1:0]     hue_o,
  output logic [hrm_pkg::PIX_W-1:0]     saturation_o,
  output logic [hrm_pkg::PIX_W-1:0]     brightness_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrm_pkg::ADDR_W-1:0]    paddr,
  input  logic [hrm_pkg::DATA_W-1:0]    pwdata,
  output logic [hrm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned NS = hrm_pkg::NUM_DIV_STEPS;

  // --------------------------------------------------------------------------
  // Bound registers
  // --------------------------------------------------------------------------
  logic [hrm_pkg::PIX_W-1:0] hue_low_q, hue_high_q;
  logic [hrm_pkg::PIX_W-1:0] sat_low_q, sat_high_q;
  logic [hrm_pkg::PIX_W-1:0] val_low_q, val_high_q;
  logic                      cfg_wr;
  hrm_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hrm_pkg::reg_idx_e'(paddr[hrm_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q  <= hrm_pkg::HUE_LOW_RST;
      hue_high_q <= hrm_pkg::HUE_HIGH_RST;
      sat_low_q  <= hrm_pkg::SAT_LOW_RST;
      sat_high_q <= hrm_pkg::SAT_HIGH_RST;
      val_low_q  <= hrm_pkg::VAL_LOW_RST;
      val_high_q <= hrm_pkg::VAL_HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        hrm_pkg::REG_HUE_LOW:  hue_low_q  <= pwdata[hrm_pkg::PIX_W-1:0];
        hrm_pkg::REG_HUE_HIGH: hue_high_q <= pwdata[hrm_pkg::PIX_W-1:0];
        hrm_pkg::REG_SAT_LOW:  sat_low_q  <= pwdata[hrm_pkg::PIX_W-1:0];
        hrm_pkg::REG_SAT_HIGH: sat_high_q <= pwdata[hrm_pkg::PIX_W-1:0];
        hrm_pkg::REG_VAL_LOW:  val_low_q  <= pwdata[hrm_pkg::PIX_W-1:0];
        hrm_pkg::REG_VAL_HIGH: val_high_q <= pwdata[hrm_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      hrm_pkg::REG_HUE_LOW:  prdata[hrm_pkg::PIX_W-1:0] = hue_low_q;
      hrm_pkg::REG_HUE_HIGH: prdata[hrm_pkg::PIX_W-1:0] = hue_high_q;
      hrm_pkg::REG_SAT_LOW:  prdata[hrm_pkg::PIX_W-1:0] = sat_low_q;
      hrm_pkg::REG_SAT_HIGH: prdata[hrm_pkg::PIX_W-1:0] = sat_high_q;
      hrm_pkg::REG_VAL_LOW:  prdata[hrm_pkg::PIX_W-1:0] = val_low_q;
      hrm_pkg::REG_VAL_HIGH: prdata[hrm_pkg::PIX_W-1:0] = val_high_q;
      default:               prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage A: largest and smallest component, and the hue numerator in units
  // of 30/diff half-degrees, already brought into the non-negative range.
  // --------------------------------------------------------------------------
  logic                       a_valid_q, a_ready;
  logic [hrm_pkg::PIX_W-1:0]  a_mx_q, a_diff_q;
  logic [hrm_pkg::UN_W-1:0]   a_un_q;
  logic [hrm_pkg::PIX_W-1:0]  mx_d, mn_d, diff_d;
  logic signed [11:0]         n_d, diff_s;
  logic [hrm_pkg::UN_W-1:0]   un_d;
  logic                       b_ready;

  always_comb begin
    mx_d = red_i;
    mn_d = red_i;
    if (green_i > mx_d) mx_d = green_i;
    if (blue_i > mx_d)  mx_d = blue_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d)  mn_d = blue_i;
    diff_d = mx_d - mn_d;
    diff_s = $signed({4'd0, diff_d});

    // Red wins a tie for the largest, then green.
    if (mx_d == red_i) begin
      n_d = $signed({4'd0, green_i}) - $signed({4'd0, blue_i});
    end else if (mx_d == green_i) begin
      n_d = $signed({4'd0, blue_i}) - $signed({4'd0, red_i}) + (diff_s <<< 1);
    end else begin
      n_d = $signed({4'd0, red_i}) - $signed({4'd0, green_i}) + (diff_s <<< 2);
    end
    if (n_d < 0) begin
      n_d = n_d + (diff_s <<< 2) + (diff_s <<< 1);
    end
    un_d = n_d[hrm_pkg::UN_W-1:0];
  end

  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_mx_q   <= mx_d;
      a_diff_q <= diff_d;
      a_un_q   <= un_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: dividends and divisors. Both rounded divisions are written as
  // (2*a + b) / (2*b). A zero divisor only occurs with a zero dividend, and
  // is replaced by one so that the quotient comes out as zero.
  // --------------------------------------------------------------------------
  logic                 b_valid_q;
  hrm_pkg::div_item_t   b_item_q, b_item_d;
  logic [NS:0]          dv_valid;
  logic [NS:0]          dv_ready;
  hrm_pkg::div_item_t   dv_data [NS+1];

  always_comb begin
    b_item_d.sat.rem = hrm_pkg::NUM_W'(a_diff_q) * hrm_pkg::NUM_W'(510)
                       + hrm_pkg::NUM_W'(a_mx_q);
    b_item_d.sat.dvs = (a_mx_q == '0) ? hrm_pkg::DVS_W'(1) : {a_mx_q, 1'b0};
    b_item_d.sat.quo = '0;
    b_item_d.hue.rem = hrm_pkg::NUM_W'(a_un_q) * hrm_pkg::NUM_W'(60)
                       + hrm_pkg::NUM_W'(a_diff_q);
    b_item_d.hue.dvs = (a_diff_q == '0) ? hrm_pkg::DVS_W'(1) : {a_diff_q, 1'b0};
    b_item_d.hue.quo = '0;
    b_item_d.val     = a_mx_q;
  end

  assign b_ready = !b_valid_q || dv_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      b_item_q <= b_item_d;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages, most significant quotient bit first.
  // --------------------------------------------------------------------------
  assign dv_valid[0] = b_valid_q;
  assign dv_data[0]  = b_item_q;

  for (genvar i = 0; i < NS; i++) begin : g_div
    hrm_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (hrm_pkg::STEP_W'(NS - 1 - i)),
      .valid_i (dv_valid[i]),
      .ready_o (dv_ready[i]),
      .data_i  (dv_data[i]),
      .valid_o (dv_valid[i+1]),
      .ready_i (dv_ready[i+1]),
      .data_o  (dv_data[i+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage C: hue wrap, bound checks and the output register.
  // --------------------------------------------------------------------------
  logic                      out_valid_q;
  logic                      c_ready;
  logic                      in_range_q, in_range_d;
  logic [hrm_pkg::PIX_W-1:0] hue_q, hue_d, sat_q, sat_d, val_q, val_d;

  always_comb begin
    hue_d = dv_data[NS].hue.quo;
    if (hue_d >= hrm_pkg::HUE_WRAP) begin
      hue_d = hue_d - hrm_pkg::HUE_WRAP;
    end
    sat_d      = dv_data[NS].sat.quo;
    val_d      = dv_data[NS].val;
    in_range_d = (hue_low_q <= hue_d) && (hue_d <= hue_high_q) &&
                 (sat_low_q <= sat_d) && (sat_d <= sat_high_q) &&
                 (val_low_q <= val_d) && (val_d <= val_high_q);
  end

  assign c_ready      = !out_valid_q || out_ready_i;
  assign dv_ready[NS] = c_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (c_ready) begin
      out_valid_q <= dv_valid[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && dv_valid[NS]) begin
      in_range_q <= in_range_d;
      hue_q      <= hue_d;
      sat_q      <= sat_d;
      val_q      <= val_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign in_range_o   = in_range_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The divisions must be complete after the last step.
  a_sat_rem_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[NS] |-> (dv_data[NS].sat.rem < hrm_pkg::NUM_W'(dv_data[NS].sat.dvs)))
    else $error("saturation remainder not below divisor after last step");

  a_hue_rem_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[NS] |-> (dv_data[NS].hue.rem < hrm_pkg::NUM_W'(dv_data[NS].hue.dvs)))
    else $error("hue remainder not below divisor after last step");

  // The wrapped hue stays on the half-degree scale.
  a_hue_scale : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < hrm_pkg::HUE_WRAP))
    else $error("hue result outside 0 to 179");

  // Zero saturation means a grey pixel, whose hue is zero.
  a_grey_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (saturation_o == '0)) |-> (hue_o == '0))
    else $error("grey pixel with non-zero hue");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV range mask testbench
// Streams BGR pixel requests through the block under several sets of bounds.
// Each accepted request is converted to HSV and tested against the bounds by
// an independent model. Every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned PIX_W          = hrm_pkg::PIX_W;
  localparam int unsigned ADDR_W         = hrm_pkg::ADDR_W;
  localparam int unsigned DATA_W         = hrm_pkg::DATA_W;
  localparam int unsigned NUM_BOUNDS     = 6;
  localparam int unsigned PIX_MAX        = 255;
  localparam int unsigned HUE_SPAN       = 180;
  localparam int unsigned MAX_WAIT       = 4;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_PIXELS   = 125;
  localparam int unsigned TOP_ADDR_IDX   = 7;

  typedef struct {
    logic             in_range;
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] sat;
    logic [PIX_W-1:0] val;
  } hsv_pixel_t;

  // Holds a copy of the bounds and the HSV pixels still owed by the block.
  class hsv_tracker;
    logic [PIX_W-1:0] bound [NUM_BOUNDS];
    hsv_pixel_t       owed [$];
    int unsigned      mismatches;

    function new();
      bound[hrm_pkg::REG_HUE_LOW]  = hrm_pkg::HUE_LOW_RST;
      bound[hrm_pkg::REG_HUE_HIGH] = hrm_pkg::HUE_HIGH_RST;
      bound[hrm_pkg::REG_SAT_LOW]  = hrm_pkg::SAT_LOW_RST;
      bound[hrm_pkg::REG_SAT_HIGH] = hrm_pkg::SAT_HIGH_RST;
      bound[hrm_pkg::REG_VAL_LOW]  = hrm_pkg::VAL_LOW_RST;
      bound[hrm_pkg::REG_VAL_HIGH] = hrm_pkg::VAL_HIGH_RST;
      mismatches                   = 0;
    endfunction

    // BGR to HSV with rounding to nearest, halves going up.
    function hsv_pixel_t convert(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] r);
      hsv_pixel_t px;
      int         top, bottom, span, num, hue, sat;
      top    = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      span = top - bottom;
      sat  = (top == 0) ? 0 : (2 * PIX_MAX * span + top) / (2 * top);
      hue  = 0;
      if (span != 0) begin
        // Red wins a tie for the largest, then green.
        if (top == int'(r)) num = int'(g) - int'(b);
        else if (top == int'(g)) num = int'(b) - int'(r) + 2 * span;
        else num = int'(r) - int'(g) + 4 * span;
        if (num < 0) num += 6 * span;
        hue = (60 * num + span) / (2 * span);
        if (hue >= HUE_SPAN) hue -= HUE_SPAN;
      end
      px.hue      = PIX_W'(hue);
      px.sat      = PIX_W'(sat);
      px.val      = PIX_W'(top);
      px.in_range = (px.hue >= bound[hrm_pkg::REG_HUE_LOW]) &&
                    (px.hue <= bound[hrm_pkg::REG_HUE_HIGH]) &&
                    (px.sat >= bound[hrm_pkg::REG_SAT_LOW]) &&
                    (px.sat <= bound[hrm_pkg::REG_SAT_HIGH]) &&
                    (px.val >= bound[hrm_pkg::REG_VAL_LOW]) &&
                    (px.val <= bound[hrm_pkg::REG_VAL_HIGH]);
      return px;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] r);
      owed.push_back(convert(b, g, r));
    endfunction

    function void check_pixel(logic in_range, logic [PIX_W-1:0] hue,
                              logic [PIX_W-1:0] sat, logic [PIX_W-1:0] val);
      hsv_pixel_t want;
      if (owed.size() == 0) begin
        $error("result arrived with no pixel request outstanding");
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (in_range !== want.in_range) begin
        $error("in_range: expected %0d, got %0d", want.in_range, in_range);
        mismatches++;
      end
      if (hue !== want.hue) begin
        $error("hue: expected %0d, got %0d", want.hue, hue);
        mismatches++;
      end
      if (sat !== want.sat) begin
        $error("saturation: expected %0d, got %0d", want.sat, sat);
        mismatches++;
      end
      if (val !== want.val) begin
        $error("brightness: expected %0d, got %0d", want.val, val);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  blue_i       = '0;
  logic [PIX_W-1:0]  green_i      = '0;
  logic [PIX_W-1:0]  red_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic              in_range_o;
  logic [PIX_W-1:0]  hue_o;
  logic [PIX_W-1:0]  saturation_o;
  logic [PIX_W-1:0]  brightness_o;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hsv_tracker  pixels      = new();
  int unsigned max_gap     = MAX_WAIT;
  int unsigned max_stall   = MAX_WAIT;
  int unsigned idle_cycles = 0;

  // Directed pixels, packed as blue, green, red from the top byte down.
  logic [3*PIX_W-1:0] directed_bgr [$] = '{
    24'h000000,  // black: no saturation, no hue
    24'hFFFFFF,  // white
    24'h808080,  // mid grey
    24'h0000FF,  // pure red
    24'h00FF00,  // pure green
    24'hFF0000,  // pure blue
    24'h00FFFF,  // red and green tie for the largest
    24'hFFFF00,  // green and blue tie
    24'hFF00FF,  // red and blue tie
    24'hC800FF,  // red largest with blue above green: negative hue
    24'h0100FF,  // hue rounds up to 180 and wraps to 0
    24'h010102,  // saturation lands exactly on a half
    24'h00013C,  // hue lands exactly on a half
    24'h010000,
    24'h000001,
    24'h000100,
    24'h7F7F80,  // smallest non-zero difference
    24'h55AA55,
    24'hAA55AA,
    24'hFE01FF,
    24'h808000,
    24'h1E0A14
  };

  hsv_range_mask dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .in_range_o  (in_range_o),
    .hue_o       (hue_o),
    .saturation_o(saturation_o),
    .brightness_o(brightness_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one pixel after a random gap and returns at the edge that takes it.
  // Valid is only lowered when a gap follows, so it is never dropped and
  // raised in the same step.
  task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] r);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_i     <= b;
    green_i    <= g;
    red_i      <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pixels.note_pixel(b, g, r);
  endtask

  // Accepts results for the whole run. Twice it holds off for a long stretch
  // so that the pipeline fills and pushes back on the pixel side.
  task automatic take_results();
    int unsigned stall, taken;
    taken = 0;
    forever begin
      if (taken == 200 || taken == 900) stall = HOLD_CYCLES;
      else stall = $urandom_range(0, max_stall);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      pixels.check_pixel(in_range_o, hue_o, saturation_o, brightness_o);
      taken++;
    end
  endtask

  // One APB transfer: setup, then access until pready, then back to idle.
  task automatic apb_xfer(input bit wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a bound with random upper bits, which the block drops, and reads
  // it back.
  task automatic set_bound(input hrm_pkg::reg_idx_e idx, input logic [PIX_W-1:0] v);
    logic [DATA_W-1:0] word, rd;
    word             = DATA_W'($urandom);
    word[PIX_W-1:0]  = v;
    apb_xfer(1'b1, ADDR_W'(4 * idx), word, rd);
    pixels.bound[idx] = v;
    apb_xfer(1'b0, ADDR_W'(4 * idx), '0, rd);
    if (rd[PIX_W-1:0] !== v) begin
      $error("readback of register %s: expected %0d, got %0d", idx.name(), v,
             rd[PIX_W-1:0]);
      pixels.mismatches++;
    end
  endtask

  task automatic set_box(input logic [PIX_W-1:0] hl, input logic [PIX_W-1:0] hh,
                         input logic [PIX_W-1:0] sl, input logic [PIX_W-1:0] sh,
                         input logic [PIX_W-1:0] vl, input logic [PIX_W-1:0] vh);
    set_bound(hrm_pkg::REG_HUE_LOW, hl);
    set_bound(hrm_pkg::REG_HUE_HIGH, hh);
    set_bound(hrm_pkg::REG_SAT_LOW, sl);
    set_bound(hrm_pkg::REG_SAT_HIGH, sh);
    set_bound(hrm_pkg::REG_VAL_LOW, vl);
    set_bound(hrm_pkg::REG_VAL_HIGH, vh);
  endtask

  // A random inclusive pair; now and then the low bound ends up above the high.
  function automatic void random_pair(input int unsigned ceiling,
                                      output logic [PIX_W-1:0] lo,
                                      output logic [PIX_W-1:0] hi);
    logic [PIX_W-1:0] a, z;
    a = PIX_W'($urandom_range(0, ceiling));
    z = PIX_W'($urandom_range(a, PIX_MAX));
    if ($urandom_range(0, 7) == 0) begin
      lo = z;
      hi = a;
    end else begin
      lo = a;
      hi = z;
    end
  endfunction

  // Mostly random pixels, with greys, ties for the largest and saturated
  // channels mixed in.
  function automatic void random_pixel(output logic [PIX_W-1:0] b,
                                       output logic [PIX_W-1:0] g,
                                       output logic [PIX_W-1:0] r);
    logic [PIX_W-1:0] hi, lo;
    hi = PIX_W'($urandom_range(0, PIX_MAX));
    lo = PIX_W'($urandom_range(0, hi));
    b  = PIX_W'($urandom);
    g  = PIX_W'($urandom);
    r  = PIX_W'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        b = hi; g = hi; r = hi;
      end
      1: begin
        b = lo; g = hi; r = hi;
      end
      2: begin
        b = hi; g = lo; r = hi;
      end
      3: begin
        b = hi; g = hi; r = lo;
      end
      4: begin
        b = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
        g = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
        r = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
      end
      default: ;
    endcase
  endfunction

  task automatic wait_drained();
    while (pixels.owed.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    take_results();
  end

  initial begin
    logic [PIX_W-1:0]  b, g, r, hl, hh, sl, sh, vl, vh;
    logic [DATA_W-1:0] rd;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels against the bounds left by reset.
    foreach (directed_bgr[i]) begin
      send_pixel(directed_bgr[i][2*PIX_W +: PIX_W], directed_bgr[i][PIX_W +: PIX_W],
                 directed_bgr[i][0 +: PIX_W]);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_box('0, 8'hFF, '0, 8'hFF, '0, 8'hFF);           // everything open
        1: set_box(8'hFF, '0, 8'hFF, '0, 8'hFF, '0);           // every pair reversed
        2: set_box('0, '0, '0, '0, '0, 8'hFF);                 // greys only
        3: set_box(8'd179, 8'd179, 8'hFF, 8'hFF, 8'hFF, 8'hFF); // top corner
        default: begin
          random_pair(HUE_SPAN - 1, hl, hh);
          random_pair(PIX_MAX, sl, sh);
          random_pair(PIX_MAX, vl, vh);
          set_box(hl, hh, sl, sh, vl, vh);
        end
      endcase
      // Writes to addresses past the last register must leave the bounds alone.
      if (p == 1) begin
        for (int a = NUM_BOUNDS; a <= TOP_ADDR_IDX; a++) begin
          apb_xfer(1'b1, ADDR_W'(4 * a), DATA_W'($urandom), rd);
        end
      end
      // Every third phase runs both sides flat out.
      max_gap   = (p % 3 == 2) ? 0 : MAX_WAIT;
      max_stall = (p % 3 == 2) ? 0 : MAX_WAIT;
      repeat (PHASE_PIXELS) begin
        random_pixel(b, g, r);
        send_pixel(b, g, r);
      end
      in_valid_i <= 1'b0;
      wait_drained();
    end

    // Give the pipeline time to show any result nobody asked for.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pixels.mismatches == 0 && pixels.owed.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### hsv_range_mask.f
design/hrm_pkg.sv
design/hrm_div_stage.sv
design/hsv_range_mask.sv
verif/tb_top.sv
